// ===== hw/rtl/dra_pkg.sv =====
// Damage rectangle accumulator: shared types, codes and constants.
// No dependencies.
`default_nettype none

package dra_pkg;

  localparam int ROW_W  = 12;          // row / column fields
  localparam int BOX_W  = 13;          // box edges, up to 8190
  localparam int LINE_W = 15;          // line length register
  localparam int PAGE_W = 16;          // page number field
  localparam int PCNT_W = 13;          // page count register
  localparam int IDX_W  = 32;          // ring indices
  localparam int CFG_W  = 15;          // widest register
  localparam int CFG_A_W = 2;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int RING_SLOTS_DEF = 64;

  localparam logic [LINE_W-1:0] LINE_BYTES_RST    = LINE_W'(3200);
  localparam logic [ROW_W-1:0]  SCREEN_WIDTH_RST  = ROW_W'(800);
  localparam logic [ROW_W-1:0]  SCREEN_HEIGHT_RST = ROW_W'(600);
  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST    = PCNT_W'(469);

  typedef enum logic [CFG_A_W-1:0] {
    CFG_LINE_BYTES    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2,
    CFG_PAGE_COUNT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_RECT  = 2'd0,
    OP_PAGE  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_FLAGS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMITTED = 2'd1,
    ST_HELD    = 2'd2,
    ST_BADPAGE = 2'd3
  } status_e;

  // request to the box store
  typedef struct packed {
    logic             merge;
    logic             clear;
    logic [BOX_W-1:0] l;
    logic [BOX_W-1:0] t;
    logic [BOX_W-1:0] r;
    logic [BOX_W-1:0] b;
  } box_cmd_t;

  typedef struct packed {
    logic [BOX_W-1:0] left;
    logic [BOX_W-1:0] right;
    logic [BOX_W-1:0] top;
    logic [BOX_W-1:0] bottom;
  } box_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dra_div.sv =====
// Iterative compare-and-subtract divider, one quotient bit a cycle,
// saturating at the row maximum. Depends on dra_pkg.
`default_nettype none

module dra_div
  import dra_pkg::*;
#(
  parameter int NUM_W = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [LINE_W-1:0] den_i,
  output logic                   done_o,
  output logic [ROW_W-1:0]       quot_o
);

  localparam int SH_W   = LINE_W + ROW_W;
  localparam int CW     = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int STEP_W = $clog2(ROW_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CW-1:0]     rem_q;
  logic [LINE_W-1:0] den_q;
  logic [ROW_W-1:0]  quot_q;

  logic [CW-1:0] den_sh, rem_sub;
  logic          ge, last, top_step;

  assign den_sh   = CW'(den_q) << step_q;
  assign ge       = rem_q >= den_sh;
  assign rem_sub  = rem_q - den_sh;
  assign last     = step_q == '0;
  // first step tests for a quotient beyond the row range
  assign top_step = step_q == STEP_W'(ROW_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && ((top_step && ge) || last)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= CW'(num_i);
      den_q  <= den_i;
      step_q <= STEP_W'(ROW_W);
      quot_q <= '0;
    end else if (busy_q) begin
      if (top_step && ge) begin
        quot_q <= '1;
      end else begin
        if (ge) begin
          rem_q <= rem_sub;
        end
        quot_q <= {quot_q[ROW_W-2:0], ge};
      end
      step_q <= step_q - STEP_W'(1);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dra_box.sv =====
// Bounding box store: merges rectangles and clears on an emitted update.
// Depends on dra_pkg.
`default_nettype none

module dra_box
  import dra_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire box_cmd_t cmd_i,
  output box_state_t    box_o
);

  box_state_t box_q, box_d;

  // an edge pair whose far edge is zero is loaded outright
  always_comb begin
    box_d = box_q;
    if (cmd_i.clear) begin
      box_d = '0;
    end else if (cmd_i.merge) begin
      if (box_q.bottom == '0) begin
        box_d.top    = cmd_i.t;
        box_d.bottom = cmd_i.b;
      end else begin
        box_d.top    = (box_q.top > cmd_i.t) ? cmd_i.t : box_q.top;
        box_d.bottom = (box_q.bottom < cmd_i.b) ? cmd_i.b : box_q.bottom;
      end
      if (box_q.right == '0) begin
        box_d.left  = cmd_i.l;
        box_d.right = cmd_i.r;
      end else begin
        box_d.left  = (box_q.left > cmd_i.l) ? cmd_i.l : box_q.left;
        box_d.right = (box_q.right < cmd_i.r) ? cmd_i.r : box_q.right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

`default_nettype wire

// ===== hw/rtl/damage_rect_accumulator_top.sv =====
// Damage rectangle accumulator, top level.
// Depends on dra_pkg, dra_div, dra_box.
//
// Usage:
//   Input requests (in_valid_i / in_stall_o) carry an opcode and its
//   operands: damage rectangle, page fault, flush tick or set flags.
//   Every request yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): a status, the update rectangle (zero
//   unless an update was emitted) and the ring producer index.
//   One request is worked on at a time; in_stall_o is high while busy.
//   Rectangle, flush, flag and out-of-range page requests go from
//   acceptance through S_EXEC to S_DONE. A page fault in range also
//   passes S_TOP_GO, S_TOP_WAIT and S_BOT_WAIT, making two passes of the
//   shared divider (13 quotient steps each); a saturated top row ends the
//   first early. The output is registered: a new request is accepted while
//   a result waits, and the block holds its finished request until the
//   output register is free when the receiver stalls. Configuration is
//   written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
//   it only while idle, as the block itself does not enforce this. Reset
//   clears box, update enable and producer index, loads defaults.
`default_nettype none

module damage_rect_accumulator_top
  import dra_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_A_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [ROW_W-1:0]   rect_x_i,
  input  wire logic [ROW_W-1:0]   rect_y_i,
  input  wire logic [ROW_W-1:0]   rect_w_i,
  input  wire logic [ROW_W-1:0]   rect_h_i,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  input  wire logic               update_enable_i,
  input  wire logic [IDX_W-1:0]   consumer_index_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic [ROW_W-1:0]        upd_x_o,
  output logic [ROW_W-1:0]        upd_y_o,
  output logic [BOX_W-1:0]        upd_w_o,
  output logic [BOX_W-1:0]        upd_h_o,
  output logic [IDX_W-1:0]        producer_index_o
);

  // byte offsets of a page end fit in the page number plus the page bits
  localparam int NUM_W = PAGE_W + $clog2(PAGE_BYTES);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_TOP_GO   = 6'b000100,
    S_TOP_WAIT = 6'b001000,
    S_BOT_WAIT = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [LINE_W-1:0] line_bytes_q;
  logic [ROW_W-1:0]  screen_width_q, screen_height_q;
  logic [PCNT_W-1:0] page_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q    <= LINE_BYTES_RST;
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
      page_count_q    <= PAGE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_BYTES:    line_bytes_q    <= cfg_data_i[LINE_W-1:0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[ROW_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[ROW_W-1:0];
        CFG_PAGE_COUNT:    page_count_q    <= cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  op_e               op_q;
  logic [ROW_W-1:0]  rx_q, ry_q, rw_q, rh_q;
  logic [PAGE_W-1:0] pn_q;
  logic              en_q;
  logic [IDX_W-1:0]  cons_q;

  logic in_acc;
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(opcode_i);
      rx_q   <= rect_x_i;
      ry_q   <= rect_y_i;
      rw_q   <= rect_w_i;
      rh_q   <= rect_h_i;
      pn_q   <= page_number_i;
      en_q   <= update_enable_i;
      cons_q <= consumer_index_i;
    end
  end

  // page-fault datapath: byte span of the page, then two divisions
  logic [NUM_W-1:0]  base_q, div_num;
  logic [LINE_W-1:0] div_den;
  logic [ROW_W-1:0]  top_row_q, bot_row_q, div_quot;
  logic              div_start, div_done, page_bad;

  assign page_bad = pn_q >= PAGE_W'(page_count_q);
  assign div_den  = (line_bytes_q == '0) ? LINE_W'(1) : line_bytes_q;
  assign div_num  = state_q == S_TOP_WAIT ? base_q + NUM_W'(PAGE_BYTES - 1) : base_q;
  assign div_start = (state_q == S_TOP_GO) || (state_q == S_TOP_WAIT && div_done);

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      base_q <= NUM_W'(pn_q) * NUM_W'(PAGE_BYTES);
    end
    if (state_q == S_TOP_WAIT && div_done) begin
      top_row_q <= div_quot;
    end
    if (state_q == S_BOT_WAIT && div_done) begin
      // bottom row clamps to the screen height
      bot_row_q <= (div_quot > screen_height_q) ? screen_height_q : div_quot;
    end
  end

  dra_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // box store and flush decision
  box_cmd_t   box_cmd;
  box_state_t box;
  logic       updates_on_q;
  logic [IDX_W-1:0] producer_q, ring_used;
  logic       ring_full, emit, out_free, finish;
  logic [BOX_W-1:0] upd_w, upd_h;
  status_e    status;
  logic       out_valid_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish    = state_q == S_DONE && out_free;
  assign ring_used = producer_q - cons_q;
  assign ring_full = ring_used >= IDX_W'(RING_SLOTS);
  assign emit      = op_q == OP_FLUSH && updates_on_q && !ring_full;
  // an inverted box edge pair is sent as zero extent
  assign upd_w     = (box.right > box.left) ? box.right - box.left : '0;
  assign upd_h     = (box.bottom > box.top) ? box.bottom - box.top : '0;

  always_comb begin
    box_cmd = '0;
    status  = ST_OK;
    unique case (op_q)
      OP_RECT: begin
        box_cmd.merge = finish;
        box_cmd.l     = BOX_W'(rx_q);
        box_cmd.t     = BOX_W'(ry_q);
        box_cmd.r     = BOX_W'(rx_q) + BOX_W'(rw_q);
        box_cmd.b     = BOX_W'(ry_q) + BOX_W'(rh_q);
      end
      OP_PAGE: begin
        if (page_bad) begin
          status = ST_BADPAGE;
        end else begin
          box_cmd.merge = finish;
          box_cmd.l     = '0;
          box_cmd.t     = BOX_W'(top_row_q);
          box_cmd.r     = BOX_W'(screen_width_q);
          box_cmd.b     = BOX_W'(bot_row_q);
        end
      end
      OP_FLUSH: begin
        status        = emit ? ST_EMITTED : ST_HELD;
        box_cmd.clear = finish && emit;
      end
      OP_FLAGS: ;
      default: ;
    endcase
  end

  dra_box u_box (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (box_cmd),
    .box_o (box)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      updates_on_q <= 1'b0;
      producer_q   <= '0;
    end else if (finish) begin
      if (op_q == OP_FLAGS) begin
        updates_on_q <= en_q;
      end
      if (emit) begin
        producer_q <= producer_q + IDX_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_acc) state_d = S_EXEC;
      S_EXEC:     state_d = (op_q == OP_PAGE && !page_bad) ? S_TOP_GO : S_DONE;
      S_TOP_GO:   state_d = S_TOP_WAIT;
      S_TOP_WAIT: if (div_done) state_d = S_BOT_WAIT;
      S_BOT_WAIT: if (div_done) state_d = S_DONE;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic [1:0]       status_q;
  logic [ROW_W-1:0] upd_x_q, upd_y_q;
  logic [BOX_W-1:0] upd_w_q, upd_h_q;
  logic [IDX_W-1:0] prod_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q   <= status;
      upd_x_q    <= emit ? box.left[ROW_W-1:0] : '0;
      upd_y_q    <= emit ? box.top[ROW_W-1:0] : '0;
      upd_w_q    <= emit ? upd_w : '0;
      upd_h_q    <= emit ? upd_h : '0;
      prod_out_q <= emit ? producer_q + IDX_W'(1) : producer_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign upd_x_o          = upd_x_q;
  assign upd_y_o          = upd_y_q;
  assign upd_w_o          = upd_w_q;
  assign upd_h_o          = upd_h_q;
  assign producer_index_o = prod_out_q;

endmodule

`default_nettype wire
